// ----- rtl/core/ohv_pkg.sv -----
// ----------------------------------------------------------------------------
// ohv_pkg
// Shared types, constants and character classes for the hostname validator.
// ----------------------------------------------------------------------------
package ohv_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned CountWidth = 7;
   localparam int unsigned WindowBytes = 8;
   localparam int unsigned WindowWidth = WindowBytes * CharWidth;

   localparam logic [WindowWidth-1:0] SFX_LONG  = 64'h2E62_3332_2E69_3270; // ".b32.i2p"
   localparam logic [31:0]            SFX_SHORT = 32'h2E69_3270;           // ".i2p"

   localparam logic [CountWidth-1:0] COUNT_MAX      = 7'd127;
   localparam logic [CountWidth-1:0] B32_TOTAL_LEN  = 7'd60;  // 52 body + 8 suffix
   localparam logic [CountWidth-1:0] HUMAN_MAX_LEN  = 7'd67;  // 63 body + 4 suffix
   localparam logic [CountWidth-1:0] LONG_SFX_LEN   = 7'd8;
   localparam logic [CountWidth-1:0] SHORT_SFX_LEN  = 7'd4;

   localparam logic [CharWidth-1:0] CH_DOT    = 8'h2E;
   localparam logic [CharWidth-1:0] CH_HYPHEN = 8'h2D;

   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_NO_SUFFIX = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_BASE32 = 2'd1;
   localparam logic [1:0] KIND_HUMAN  = 2'd2;

   typedef struct packed {
      logic [CharWidth-1:0] host_char;
      logic                 last_char;
   } ohv_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] address_kind;
   } ohv_rsp_type;

   function automatic logic is_b32_sym(input logic [CharWidth-1:0] c);
      is_b32_sym = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h32 && c <= 8'h37);
   endfunction

   function automatic logic is_human_sym(input logic [CharWidth-1:0] c);
      is_human_sym = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
                     c == CH_DOT || c == CH_HYPHEN;
   endfunction

endpackage

// ----- rtl/core/ohv_scan.sv -----
// ----------------------------------------------------------------------------
// ohv_scan
// Per-name scan state: tail window, saturating count and sticky flags.
// Produces the verdict combinationally for the final word of a name.
// ----------------------------------------------------------------------------
module ohv_scan
   import ohv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  ohv_req_type req,
   output ohv_rsp_type verdict
);

   logic [WindowWidth-1:0] window_ff, window_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   lead_bad_ff, lead_bad_in;
   logic                   b32_ok_ff, b32_ok_in;
   logic                   human_ok_ff, human_ok_in;
   logic                   pairs_ok_ff, pairs_ok_in;

   logic [CharWidth-1:0] c, prev, evicted;

   always_comb begin
      c       = req.host_char;
      prev    = window_ff[CharWidth-1:0];
      evicted = window_ff[WindowWidth-1 -: CharWidth];

      lead_bad_in = lead_bad_ff;
      pairs_ok_in = pairs_ok_ff;
      if (count_ff == '0) begin
         if (c == CH_DOT || c == CH_HYPHEN) lead_bad_in = 1'b1;
      end else begin
         if ((prev == CH_DOT && (c == CH_DOT || c == CH_HYPHEN)) ||
             (prev == CH_HYPHEN && c == CH_DOT)) pairs_ok_in = 1'b0;
      end
      b32_ok_in   = b32_ok_ff & ~(count_ff >= LONG_SFX_LEN && !is_b32_sym(evicted));
      human_ok_in = human_ok_ff & is_human_sym(c);
      window_in   = {window_ff[WindowWidth-CharWidth-1:0], c};
      count_in    = (count_ff < COUNT_MAX) ? count_ff + 7'd1 : count_ff;

      if (count_in >= LONG_SFX_LEN && window_in == SFX_LONG) begin
         verdict.address_kind = KIND_BASE32;
         verdict.status = (count_in == B32_TOTAL_LEN && b32_ok_in) ? ST_VALID : ST_INVALID;
      end else if (count_in >= SHORT_SFX_LEN && window_in[31:0] == SFX_SHORT) begin
         verdict.address_kind = KIND_HUMAN;
         verdict.status = (count_in <= HUMAN_MAX_LEN && !lead_bad_in && human_ok_in &&
                           pairs_ok_in) ? ST_VALID : ST_INVALID;
      end else begin
         verdict.address_kind = KIND_NONE;
         verdict.status       = ST_NO_SUFFIX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.last_char)) begin
         window_ff   <= '0;
         count_ff    <= '0;
         lead_bad_ff <= 1'b0;
         b32_ok_ff   <= 1'b1;
         human_ok_ff <= 1'b1;
         pairs_ok_ff <= 1'b1;
      end else if (step) begin
         window_ff   <= window_in;
         count_ff    <= count_in;
         lead_bad_ff <= lead_bad_in;
         b32_ok_ff   <= b32_ok_in;
         human_ok_ff <= human_ok_in;
         pairs_ok_ff <= pairs_ok_in;
      end
   end

endmodule

// ----- rtl/core/overlay_hostname_validator_core.sv -----
// ----------------------------------------------------------------------------
// overlay_hostname_validator_core
// Streaming hostname checker for overlay-network names (.b32.i2p / .i2p).
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one hostname byte per word; last_char marks the
//   final word of a name. Names are at least one byte long.
//   rsp_ channel returns one word (status, address_kind) per name, for its
//   final word only; other words produce nothing.
//   Latency: the result is registered and shows on rsp_valid the cycle after
//   the final word is accepted.
//   Throughput: one word per cycle. Scan state updates on every accepted
//   word; the verdict goes to the result register in the same cycle.
//   req_ready is low only while a result is held and rsp_ready is low, so
//   a stalled receiver stops the input; nothing is dropped.
//   Reset: synchronous; clears the scan state and the result valid flag.
//   After each final word the scan state returns to its reset values.
// ----------------------------------------------------------------------------
module overlay_hostname_validator_core
   import ohv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ohv_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ohv_rsp_type rsp_payload
);

   logic        rsp_valid_ff, rsp_valid_in;
   ohv_rsp_type rsp_data_ff;
   ohv_rsp_type verdict;
   logic        step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   ohv_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .req     (req_payload),
      .verdict (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step && req_payload.last_char) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && req_payload.last_char) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step && req_payload.last_char) |=> rsp_valid)
      else $error("final word did not produce a result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      (step && !req_payload.last_char && rsp_ready) |=> !rsp_valid)
      else $error("result produced for a non-final word");

   a_kind_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.address_kind == KIND_NONE) |->
      rsp_payload.status == ST_NO_SUFFIX)
      else $error("unknown suffix with wrong status");

   a_codes_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status != 2'd3 && rsp_payload.address_kind != 2'd3))
      else $error("illegal result code");

endmodule

// ----- test/overlay_hostname_validator_core_tb.sv -----
// ----------------------------------------------------------------------------
// overlay_hostname_validator_core_tb
// Self-checking bench for the streaming overlay hostname validator.
// Hostnames go in byte by byte on the req_ channel. A cycle-level scan model
// tracks the shift window, byte count and validity flags. On each final byte
// it queues the expected status and address kind, and every rsp_ word is
// checked against that queue. A short list of directed names is followed by
// random base32, human-readable, near-miss and noise names. Sender bursts and
// receiver stalls vary, with one long receiver hold and idle points between
// names.
// ----------------------------------------------------------------------------
module overlay_hostname_validator_core_tb;
   import ohv_pkg::*;

   localparam int CycleLimit = 400000;

   typedef struct {
      ohv_req_type word;
      bit          wait_idle;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ohv_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ohv_rsp_type rsp_payload;

   overlay_hostname_validator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   pending_type feed_q[$];
   logic [7:0]  name_buf[$];
   ohv_rsp_type verdict_q[$];
   int          total_words = 0;
   int          name_count = 0;
   int          words_sent = 0;
   int          finals_sent = 0;
   int          rsp_count = 0;
   int          errors = 0;
   int          cycle_count = 0;

   // scan model state
   logic [63:0] win;
   logic [6:0]  cnt;
   logic        lead_bad, b32_ok, hum_ok, pairs_ok;

   function automatic bit b32_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "2" && c <= "7");
   endfunction

   function automatic bit dns_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == CH_DOT ||
             c == CH_HYPHEN;
   endfunction

   task automatic clear_scan();
      win = '0;
      cnt = '0;
      lead_bad = 1'b0;
      b32_ok = 1'b1;
      hum_ok = 1'b1;
      pairs_ok = 1'b1;
   endtask

   task automatic scan_word(input ohv_req_type w);
      logic [7:0]  c, prev, old;
      ohv_rsp_type v;
      c = w.host_char;
      prev = win[7:0];
      old = win[63:56];
      if (cnt == 0) begin
         if (c == CH_DOT || c == CH_HYPHEN) lead_bad = 1'b1;
      end else if ((prev == CH_DOT && (c == CH_DOT || c == CH_HYPHEN)) ||
                   (prev == CH_HYPHEN && c == CH_DOT)) begin
         pairs_ok = 1'b0;
      end
      if (cnt >= LONG_SFX_LEN && !b32_char(old)) b32_ok = 1'b0;
      if (!dns_char(c)) hum_ok = 1'b0;
      win = {win[55:0], c};
      if (cnt != COUNT_MAX) cnt = cnt + 7'd1;
      if (w.last_char) begin
         if (cnt >= LONG_SFX_LEN && win == SFX_LONG) begin
            v.address_kind = KIND_BASE32;
            v.status = (cnt == B32_TOTAL_LEN && b32_ok) ? ST_VALID : ST_INVALID;
         end else if (cnt >= SHORT_SFX_LEN && win[31:0] == SFX_SHORT) begin
            v.address_kind = KIND_HUMAN;
            v.status = (cnt <= HUMAN_MAX_LEN && !lead_bad && hum_ok && pairs_ok) ?
                       ST_VALID : ST_INVALID;
         end else begin
            v.address_kind = KIND_NONE;
            v.status = ST_NO_SUFFIX;
         end
         verdict_q.push_back(v);
         clear_scan();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   // name building
   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
   endtask

   task automatic put_rep(input logic [7:0] c, input int n);
      repeat (n) name_buf.push_back(c);
   endtask

   task automatic put_b32(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 57);
         if (r < 26) name_buf.push_back(8'(int'("A") + r));
         else if (r < 52) name_buf.push_back(8'(int'("a") + r - 26));
         else name_buf.push_back(8'(int'("2") + r - 52));
      end
   endtask

   task automatic put_dns(input int n);
      int r;
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            name_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_HYPHEN);
         end else begin
            r = $urandom_range(0, 35);
            name_buf.push_back(r < 26 ? 8'(int'("a") + r) : 8'(int'("0") + r - 26));
         end
      end
   endtask

   task automatic put_noise(input int n);
      repeat (n) name_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic commit_name(input bit wait_idle);
      pending_type p;
      for (int i = 0; i < name_buf.size(); i++) begin
         p.word.host_char = name_buf[i];
         p.word.last_char = (i == name_buf.size() - 1);
         p.wait_idle = wait_idle && (i == 0);
         feed_q.push_back(p);
      end
      total_words += name_buf.size();
      name_count++;
      name_buf.delete();
   endtask

   task automatic random_name(input bit wait_idle);
      int pick, n;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(49, 55) : 52;
         put_b32(n);
         if ($urandom_range(0, 9) == 0) name_buf[$urandom_range(0, n - 1)] =
            8'($urandom_range(0, 255));
         put_str(".b32.i2p");
      end else if (pick < 70) begin
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 20);
         put_dns(n);
         if ($urandom_range(0, 29) == 0) name_buf[0] = $urandom_range(0, 1) ? CH_DOT : CH_HYPHEN;
         if ($urandom_range(0, 24) == 0) name_buf[$urandom_range(0, n - 1)] =
            8'($urandom_range(0, 255));
         put_str(".i2p");
      end else if (pick < 85) begin
         put_dns($urandom_range(0, 12));
         case ($urandom_range(0, 6))
            0: put_str(".i2");
            1: put_str("i2p");
            2: put_str(".i2q");
            3: put_str(".I2P");
            4: put_str(".b32.i2p");
            5: put_str(".b32i2p");
            default: put_str("-.i2p");
         endcase
      end else begin
         put_noise($urandom_range(1, 24));
      end
      commit_name(wait_idle);
   endtask

   // driver
   int          burst_left = 8;
   int          gap_left = 0;
   bit          took;
   pending_type nxt;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            words_sent <= words_sent + 1;
            if (req_payload.last_char) finals_sent <= finals_sent + 1;
         end
         if (req_valid && !took) begin
            // hold word until accepted
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (feed_q.size() == 0 || (feed_q[0].wait_idle &&
                      finals_sent + int'(took && req_payload.last_char) != rsp_count)) begin
            req_valid <= 1'b0;
         end else begin
            nxt = feed_q.pop_front();
            req_payload <= nxt.word;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver
   int hold_left = 0;
   bit hold_done = 1'b0;
   int rx_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && words_sent >= 300) begin
            hold_left = 250;
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            case ((rx_cycle / 97) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (rx_cycle % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 99) < 85);
            endcase
         end
      end
   end

   // monitor
   ohv_rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
      end else begin
         if (req_valid && req_ready) scan_word(req_payload);
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h", rsp_payload));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_payload.status,
                                            want.status));
               if (rsp_payload.address_kind !== want.address_kind)
                  report_mismatch($sformatf("address_kind %0d, want %0d",
                                            rsp_payload.address_kind, want.address_kind));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      // directed names
      put_str("a");                                   commit_name(1'b0);
      put_b32(52); put_str(".b32.i2p");               commit_name(1'b0);
      put_b32(51); put_str(".b32.i2p");               commit_name(1'b0);
      put_b32(53); put_str(".b32.i2p");               commit_name(1'b0);
      put_b32(30); put_str("1"); put_b32(21); put_str(".b32.i2p"); commit_name(1'b0);
      put_str("example.i2p");                         commit_name(1'b0);
      put_str("-ab.i2p");                             commit_name(1'b0);
      put_str(".ab.i2p");                             commit_name(1'b0);
      put_str("a..b.i2p");                            commit_name(1'b0);
      put_str("a.-b.i2p");                            commit_name(1'b0);
      put_str("a-.b.i2p");                            commit_name(1'b0);
      put_str("a--b.i2p");                            commit_name(1'b0);
      put_rep("x", 63); put_str(".i2p");              commit_name(1'b0);
      put_rep("x", 64); put_str(".i2p");              commit_name(1'b0);
      put_str("ABC.i2p");                             commit_name(1'b0);
      put_str(".i2p");                                commit_name(1'b0);
      put_str(".b32.i2p");                            commit_name(1'b0);
      put_rep("q", 140); put_str(".i2p");             commit_name(1'b0);
      put_b32(140); put_str(".b32.i2p");              commit_name(1'b0);
      put_str("a"); put_rep(8'hFF, 1); put_rep(8'h80, 1); put_str(".i2p"); commit_name(1'b0);
      put_str("x"); put_rep(8'h00, 1); put_str("y.i2p"); commit_name(1'b0);
      put_str("example.com");                         commit_name(1'b0);
      put_str("ab-.i2p");                             commit_name(1'b0);
      // random names, with idle points
      random_name(1'b1);
      while (total_words < 800 || name_count < 28)
         random_name(name_count == 26);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != total_words || finals_sent != rsp_count) @(posedge clock);
      repeat (6) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- overlay_hostname_validator_core.f -----
rtl/core/ohv_pkg.sv
rtl/core/ohv_scan.sv
rtl/core/overlay_hostname_validator_core.sv
test/overlay_hostname_validator_core_tb.sv
